FILE: sv/load_mirror_migration_select_assert.svh
// Assertion macros used by the load mirror migration select controller.
`ifndef LOAD_MIRROR_MIGRATION_SELECT_ASSERT_SVH
`define LOAD_MIRROR_MIGRATION_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LMMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LMMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LMMS_ASSERT(lbl, prop, msg)
`define LMMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/lmms_pkg.sv
// Package with sizes, types and register codes of the load mirror migration select block.
`default_nettype none
package lmms_pkg;
    localparam int MAX_RANKS = 64;
    localparam int LOAD_BITS = 16;
    localparam int RANK_W = $clog2(MAX_RANKS);
    localparam int CNT_W = $clog2(MAX_RANKS + 1);

    localparam int OWN_RANK_W = 6;
    localparam int RANK_COUNT_W = 7;
    localparam int IN_LOAD_W = 16;
    localparam int TASKS_W = 16;
    localparam int TID_W = 32;
    localparam int TARGET_W = 6;
    localparam int IN_W = 64;
    localparam int OUT_W = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT = 2'd1;

    typedef logic [LOAD_BITS-1:0] t_load;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic  vld;
        t_load load;
        t_rank idx;
        t_rank pos;
    } t_token;

    typedef struct packed {
        logic  wr_en;
        t_rank wr_idx;
        t_load wr_load;
        logic  init;
        logic  shift;
        logic  count;
        logic  load_pos;
        t_cnt  n;
    } t_cell_cmd;
endpackage
`default_nettype wire

FILE: sv/lmms_cell.sv
// One rank cell: holds a load, ranks it against the token ring and passes its token on.
`default_nettype none
module lmms_cell
    import lmms_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_rank     i_idx,
    input  wire t_cell_cmd i_cmd,
    input  wire t_token    i_tok,
    output t_token         o_tok
);
    t_load  r_load;
    t_token r_tok;
    t_rank  r_pos;
    logic   w_below;
    logic   w_wr;

    assign w_wr    = i_cmd.wr_en && (i_cmd.wr_idx == i_idx);
    assign w_below = r_tok.vld &&
                     ((r_tok.load < r_load) || ((r_tok.load == r_load) && (r_tok.idx < i_idx)));

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_load <= i_cmd.wr_load;
        end
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_pos     <= '0;
        end else if (i_cmd.init) begin
            r_tok.vld  <= (CNT_W'(i_idx) < i_cmd.n);
            r_tok.load <= w_wr ? i_cmd.wr_load : r_load;
            r_tok.idx  <= i_idx;
            r_tok.pos  <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cmd.count && w_below) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.shift) begin
                r_tok <= i_tok;
            end else if (i_cmd.load_pos) begin
                r_tok.pos <= r_pos;
            end
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

FILE: sv/lmms_ctrl.sv
// Controller: load collection, configuration registers, ring sequencing and the decision.
`default_nettype none
`include "load_mirror_migration_select_assert.svh"
module lmms_ctrl
    import lmms_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_valid,
    output logic                         o_s_ready,
    input  wire logic [IN_LOAD_W-1:0]    i_load,
    input  wire logic [TASKS_W-1:0]      i_tasks,
    input  wire logic [TID_W-1:0]        i_tid,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [RANK_COUNT_W-1:0] i_cfg_data,
    output t_cell_cmd                    o_cmd,
    input  wire t_token                  i_tail,
    output logic                         o_m_valid,
    input  wire logic                    i_m_ready,
    output logic                         o_migrate,
    output logic [TID_W-1:0]             o_task_id,
    output logic [TARGET_W-1:0]          o_target
);
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_ROT1,
        ST_LDPOS,
        ST_ROT2,
        ST_ROT3,
        ST_DECIDE
    } t_state;

    localparam t_rank STEP_LAST = RANK_W'(MAX_RANKS - 1);

    t_state                  r_state;
    t_rank                   r_step;
    t_cnt                    r_item_count;
    logic [OWN_RANK_W-1:0]   r_own_rank;
    logic [RANK_COUNT_W-1:0] r_rank_count;
    logic [TASKS_W-1:0]      r_tasks;
    logic [TID_W-1:0]        r_tid;
    t_load                   r_lo;
    t_load                   r_hi;
    t_load                   r_own_load;
    t_rank                   r_own_pos;
    t_rank                   r_partner;
    t_load                   r_partner_load;
    logic                    r_m_valid;
    logic                    r_migrate;
    logic [TID_W-1:0]        r_task_id;
    logic [TARGET_W-1:0]     r_target;

    t_cnt w_n;
    t_cnt w_cnt_inc;
    t_cnt w_mirror;
    logic w_acc;
    logic w_last;
    logic w_own_tail;
    logic w_own_valid;
    logic w_upper;
    logic w_mig;

    always_comb begin
        if (r_rank_count == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_rank_count) > 32'(MAX_RANKS)) begin
            w_n = CNT_W'(MAX_RANKS);
        end else begin
            w_n = CNT_W'(r_rank_count);
        end
    end

    assign w_cnt_inc   = r_item_count + 1'b1;
    assign w_last      = (w_cnt_inc >= w_n);
    assign o_s_ready   = (r_state == ST_COLLECT);
    assign w_acc       = i_s_valid && o_s_ready;
    assign o_cfg_ready = 1'b1;
    assign w_own_tail  = i_tail.vld && (32'(i_tail.idx) == 32'(r_own_rank));
    assign w_own_valid = (32'(r_own_rank) < 32'(w_n));
    assign w_mirror    = w_n - 1'b1 - CNT_W'(r_own_pos);
    assign w_upper     = ({CNT_W'(r_own_pos) + 1'b1, 1'b0} >= {1'b0, w_n});
    assign w_mig       = w_own_valid && (r_tasks != '0) && (r_hi > r_lo) && w_upper &&
                         ({r_partner_load, 1'b0} < {1'b0, r_own_load});

    always_comb begin
        o_cmd.wr_en    = w_acc && (32'(r_item_count) < 32'(MAX_RANKS));
        o_cmd.wr_idx   = r_item_count[RANK_W-1:0];
        o_cmd.wr_load  = t_load'(i_load);
        o_cmd.init     = w_acc && w_last;
        o_cmd.shift    = (r_state == ST_ROT1) || (r_state == ST_ROT2) || (r_state == ST_ROT3);
        o_cmd.count    = (r_state == ST_ROT1);
        o_cmd.load_pos = (r_state == ST_LDPOS);
        o_cmd.n        = w_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_COLLECT;
            r_step       <= '0;
            r_item_count <= '0;
            r_own_rank   <= '0;
            r_rank_count <= RANK_COUNT_W'(1);
            r_own_load   <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OWN_RANK: begin
                        r_own_rank <= i_cfg_data[OWN_RANK_W-1:0];
                    end
                    CFG_RANK_COUNT: begin
                        r_rank_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_m_valid && i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_COLLECT: begin
                    if (w_acc) begin
                        r_tasks <= i_tasks;
                        r_tid   <= i_tid;
                        if (w_last) begin
                            r_item_count <= '0;
                            r_step       <= '0;
                            r_lo         <= '1;
                            r_hi         <= '0;
                            r_own_load   <= '0;
                            r_state      <= ST_ROT1;
                        end else begin
                            r_item_count <= w_cnt_inc;
                        end
                    end
                end
                ST_ROT1: begin
                    if (i_tail.vld) begin
                        if (i_tail.load < r_lo) begin
                            r_lo <= i_tail.load;
                        end
                        if (i_tail.load > r_hi) begin
                            r_hi <= i_tail.load;
                        end
                    end
                    if (w_own_tail) begin
                        r_own_load <= i_tail.load;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_LDPOS;
                    end
                end
                ST_LDPOS: begin
                    r_step  <= '0;
                    r_state <= ST_ROT2;
                end
                ST_ROT2: begin
                    if (w_own_tail) begin
                        r_own_pos <= i_tail.pos;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_step  <= '0;
                        r_state <= ST_ROT3;
                    end
                end
                ST_ROT3: begin
                    if (i_tail.vld && (CNT_W'(i_tail.pos) == w_mirror)) begin
                        r_partner      <= i_tail.idx;
                        r_partner_load <= i_tail.load;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (!r_m_valid || i_m_ready) begin
                        r_m_valid <= 1'b1;
                        r_migrate <= w_mig;
                        r_task_id <= w_mig ? r_tid : '0;
                        r_target  <= w_mig ? TARGET_W'(r_partner) : '0;
                        r_state   <= ST_COLLECT;
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_migrate = r_migrate;
    assign o_task_id = r_task_id;
    assign o_target  = r_target;

    `LMMS_ASSERT(a_count_range, 32'(r_item_count) < 32'(MAX_RANKS), "Load counter out of range.")
    `LMMS_ASSERT(a_result_source, (r_m_valid && !$past(r_m_valid)) |-> ($past(r_state) == ST_DECIDE), "Result raised outside the decision step.")
    `LMMS_ASSERT(a_no_move_zero, (r_m_valid && !r_migrate) |-> ((r_task_id == '0) && (r_target == '0)), "Fields not cleared without a migration.")
    `LMMS_ASSERT(a_ring_start, o_cmd.init |=> ((r_state == ST_ROT1) && (r_step == '0)), "Ring pass did not start after the last load.")
    `LMMS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> ((r_state == ST_COLLECT) && !r_m_valid), "Reset did not return to collection.")
endmodule
`default_nettype wire

FILE: sv/load_mirror_migration_select.sv
// Top level of the load mirror migration select block: controller and ring of rank cells.
//
// Loads arrive on the slave stream, one request per rank in rank order, with the local
// task count and first task id in the same request. Configuration writes go through the
// cfg channel (index 0 own rank, index 1 rank count), which is always ready.
// After the request carrying the last rank's load, the block stops taking loads and runs
// the stored loads three times around a ring of 64 cells: once to rank every load against
// all others, and twice to pick up the own position and then the mirrored partner.
// One decision request then appears on the master stream after the rank pass, the
// position load step, the two further passes and the decision step; every pass walks
// the full ring length, not the rank count. Loads before the last are taken as offered.
// The decision sits in an output register; while the receiver stalls, the next round's
// loads are still taken, and only the next decision waits for the register to empty.
// Reset is synchronous: the load count and the output valid clear, own rank becomes 0 and
// rank count becomes 1. Stored loads are not cleared; only loads of the current round
// are ever used.
`default_nettype none
module load_mirror_migration_select
    import lmms_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    // rank_load[15:0], local_task_count[31:16], first_task_id[63:32]
    input  wire logic [IN_W-1:0]         i_s_tdata,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    // task_id[31:0], target_rank[37:32], zero fill[39:38]
    output logic [OUT_W-1:0]             o_m_tdata,
    // migrate[0]
    output logic                         o_m_tuser,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [RANK_COUNT_W-1:0] i_cfg_data
);
    t_cell_cmd           w_cmd;
    t_token              w_tok [MAX_RANKS];
    logic [TID_W-1:0]    w_task_id;
    logic [TARGET_W-1:0] w_target;

    lmms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_tvalid),
        .o_s_ready   (o_s_tready),
        .i_load      (i_s_tdata[15:0]),
        .i_tasks     (i_s_tdata[31:16]),
        .i_tid       (i_s_tdata[63:32]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_tail      (w_tok[MAX_RANKS-1]),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_migrate   (o_m_tuser),
        .o_task_id   (w_task_id),
        .o_target    (w_target)
    );

    for (genvar g = 0; g < MAX_RANKS; g++) begin : g_cell
        lmms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (RANK_W'(g)),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[(g + MAX_RANKS - 1) % MAX_RANKS]),
            .o_tok   (w_tok[g])
        );
    end

    assign o_m_tdata = {2'b00, w_target, w_task_id};
endmodule
`default_nettype wire
